>>> src/rvie_pkg.sv
package rvie_pkg;

   // opcodes of an execute beat
   localparam logic [3:0] OP_LOADCONST = 4'd0;
   localparam logic [3:0] OP_ADD       = 4'd1;
   localparam logic [3:0] OP_SUB       = 4'd2;
   localparam logic [3:0] OP_MUL       = 4'd3;
   localparam logic [3:0] OP_DIV       = 4'd4;
   localparam logic [3:0] OP_JMP       = 4'd5;
   localparam logic [3:0] OP_LOADIMM   = 4'd6;
   localparam logic [3:0] OP_MOVE      = 4'd7;
   localparam logic [3:0] OP_EQ        = 4'd8;
   localparam logic [3:0] OP_LT        = 4'd9;
   localparam logic [3:0] OP_LE        = 4'd10;
   localparam logic [3:0] OP_GT        = 4'd11;
   localparam logic [3:0] OP_GE        = 4'd12;
   localparam logic [3:0] OP_NOP       = 4'd13;
   localparam logic [3:0] OP_HALT      = 4'd14;

   typedef struct packed {
      logic               command;
      logic [3:0]         opcode;
      logic [7:0]         field_a;
      logic [7:0]         field_b;
      logic [7:0]         field_c;
      logic [9:0]         const_index;
      logic signed [7:0]  jump_offset;
      logic signed [31:0] const_data;
   } req_type;

   typedef struct packed {
      logic signed [8:0]  pc_step;
      logic               halted;
      logic               reg_written;
      logic signed [31:0] written_value;
      logic               div_zero;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_CONST_WR,
      KIND_REG_OP,
      KIND_MUL,
      KIND_DIV,
      KIND_CMP,
      KIND_JMP,
      KIND_NOP,
      KIND_HALT
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [3:0]        opcode;
      logic [7:0]        field_a;
      logic [7:0]        field_b;
      logic [7:0]        field_c;
      logic signed [7:0] jump_offset;
   } entry_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_LOAD,
      BS_EXEC,
      BS_ITER,
      BS_FIN
   } back_state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } iter_cmd_type;

endpackage

>>> src/rvie_front.sv
module rvie_front #(
   parameter int NUM_CONSTANTS = 1024,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  rvie_pkg::req_type        req,
   output logic                     out_valid,
   output rvie_pkg::entry_type      out_entry,
   output logic [VALUE_WIDTH-1:0]   out_value,
   input  logic                     out_full
);
   import rvie_pkg::*;

   localparam int CW = (NUM_CONSTANTS > 1) ? $clog2(NUM_CONSTANTS) : 1;

   logic [VALUE_WIDTH-1:0] cmem [NUM_CONSTANTS];

   logic                   s1_valid_ff, s1_valid_in;
   entry_type              s1_entry_ff, s1_entry_in;
   logic                   const_ok_ff;
   logic [VALUE_WIDTH-1:0] const_rd_ff;
   logic                   accept;
   logic                   ci_ok;
   logic [CW-1:0]          caddr;
   logic signed [63:0]     data_ext;
   kind_type               kind;

   assign accept   = push & ~full;
   assign full     = s1_valid_ff & out_full;
   assign ci_ok    = (32'(req.const_index) < 32'(NUM_CONSTANTS));
   assign caddr    = CW'(req.const_index);
   assign data_ext = 64'(req.const_data);

   // classify the beat
   always_comb begin
      if (req.command) begin
         kind = KIND_CONST_WR;
      end else begin
         unique case (req.opcode) inside
            OP_LOADCONST, OP_ADD, OP_SUB, OP_LOADIMM, OP_MOVE: kind = KIND_REG_OP;
            OP_MUL:                                           kind = KIND_MUL;
            OP_DIV:                                           kind = KIND_DIV;
            OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE:                kind = KIND_CMP;
            OP_JMP:                                           kind = KIND_JMP;
            OP_HALT:                                          kind = KIND_HALT;
            default:                                          kind = KIND_NOP;
         endcase
      end
   end

   always_comb begin
      s1_entry_in.kind        = kind;
      s1_entry_in.opcode      = req.opcode;
      s1_entry_in.field_a     = req.field_a;
      s1_entry_in.field_b     = req.field_b;
      s1_entry_in.field_c     = req.field_c;
      s1_entry_in.jump_offset = req.jump_offset;
   end

   assign s1_valid_in = accept | (s1_valid_ff & out_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_entry_ff <= s1_entry_in;
         const_ok_ff <= ci_ok;
      end
   end

   // constant store, read data registered
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req.command && ci_ok) begin
            cmem[caddr] <= VALUE_WIDTH'(data_ext);
         end
         const_rd_ff <= cmem[caddr];
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_entry = s1_entry_ff;
   assign out_value = const_ok_ff ? const_rd_ff : '0;

endmodule

>>> src/rvie_fifo.sv
module rvie_fifo #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);

   localparam int DEPTH = 2;
   localparam int AW    = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = push & ~full;
   assign do_rd = pop & ~empty;
   assign dout  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> src/rvie_iter.sv
module rvie_iter #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rvie_pkg::iter_cmd_type cmd,
   input  logic [VALUE_WIDTH-1:0] op_b,
   input  logic [VALUE_WIDTH-1:0] op_c,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);
   import rvie_pkg::*;

   localparam int VW   = VALUE_WIDTH;
   localparam int CNTW = $clog2(VW + 1);

   logic            busy_ff, done_ff, div_ff, neg_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [VW-1:0]   acc_ff, x_ff, y_ff;
   logic [VW:0]     shifted, trial;
   logic            fits;
   logic [VW-1:0]   mag_b, mag_c;

   assign mag_b   = op_b[VW-1] ? (VW'(0) - op_b) : op_b;
   assign mag_c   = op_c[VW-1] ? (VW'(0) - op_c) : op_c;
   assign shifted = {acc_ff, x_ff[VW-1]};
   assign trial   = shifted - {1'b0, y_ff};
   assign fits    = (shifted >= {1'b0, y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNTW'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNTW'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // one multiplier bit or one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cnt_ff <= CNTW'(VW);
         div_ff <= cmd.is_div;
         neg_ff <= op_b[VW-1] ^ op_c[VW-1];
         acc_ff <= '0;
         x_ff   <= cmd.is_div ? mag_b : op_b;
         y_ff   <= cmd.is_div ? mag_c : op_c;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (div_ff) begin
            acc_ff <= fits ? trial[VW-1:0] : shifted[VW-1:0];
            x_ff   <= {x_ff[VW-2:0], fits};
         end else begin
            if (y_ff[0]) begin
               acc_ff <= acc_ff + x_ff;
            end
            x_ff <= {x_ff[VW-2:0], 1'b0};
            y_ff <= {1'b0, y_ff[VW-1:1]};
         end
      end
   end

   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (VW'(0) - x_ff) : x_ff) : acc_ff;

endmodule

>>> src/rvie_back.sv
module rvie_back #(
   parameter int NUM_REGISTERS = 256,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_pop,
   input  rvie_pkg::entry_type    in_entry,
   input  logic [VALUE_WIDTH-1:0] in_value,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rvie_pkg::rsp_type      rsp_data
);
   import rvie_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int RW = $clog2(NUM_REGISTERS);

   logic [VW-1:0] rmem [NUM_REGISTERS];
   logic          vld_ff [NUM_REGISTERS];

   back_state_type state_ff, state_in;
   entry_type      work_ff;
   logic [VW-1:0]  cval_ff, opb_ff, opc_ff, fin_val_ff;
   logic [VW-1:0]  rdata0_ff, rdata1_ff, rval0, rval1;
   logic           rok0_ff, rok1_ff;
   logic           rd_en;
   logic [7:0]     addr0, addr1;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           slot_free, go_iter, fire, wr_en, cmp;
   logic signed [8:0] step;
   logic           halted, wr, dz;
   logic [VW-1:0]  val;
   iter_cmd_type   iter_cmd;
   logic           iter_done;
   logic [VW-1:0]  iter_result;

   function automatic logic reg_ok(input logic [7:0] idx);
      return (9'(idx) < 9'(NUM_REGISTERS));
   endfunction

   rvie_iter #(.VALUE_WIDTH(VW)) u_iter (
      .clock  (clock),
      .reset  (reset),
      .cmd    (iter_cmd),
      .op_b   (opb_ff),
      .op_c   (opc_ff),
      .done   (iter_done),
      .result (iter_result)
   );

   assign slot_free = ~rsp_valid_ff | rsp_pop;
   assign go_iter   = (work_ff.kind == KIND_MUL) ||
                      ((work_ff.kind == KIND_DIV) && (opc_ff != '0));
   assign rval0     = rok0_ff ? rdata0_ff : '0;
   assign rval1     = rok1_ff ? rdata1_ff : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BS_IDLE: if (in_valid) state_in = BS_LOAD;
         BS_LOAD: state_in = BS_EXEC;
         BS_EXEC: begin
            if (go_iter) begin
               state_in = BS_ITER;
            end else if (slot_free) begin
               state_in = BS_IDLE;
            end
         end
         BS_ITER: if (iter_done) state_in = BS_FIN;
         BS_FIN:  if (slot_free) state_in = BS_IDLE;
         default: state_in = BS_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      in_pop          = 1'b0;
      rd_en           = 1'b0;
      addr0           = work_ff.field_a;
      addr1           = in_entry.field_c;
      iter_cmd.start  = 1'b0;
      iter_cmd.is_div = (work_ff.kind == KIND_DIV);
      fire            = 1'b0;
      unique case (state_ff)
         BS_IDLE: begin
            in_pop = in_valid;
            rd_en  = in_valid;
            addr0  = in_entry.field_b;
         end
         BS_LOAD: rd_en = 1'b1;
         BS_EXEC: begin
            iter_cmd.start = go_iter;
            fire           = ~go_iter & slot_free;
         end
         BS_ITER: ;
         BS_FIN:  fire = slot_free;
         default: ;
      endcase
   end

   // result of the instruction
   always_comb begin
      step   = 9'sd1;
      halted = 1'b0;
      wr     = 1'b0;
      val    = '0;
      dz     = 1'b0;
      cmp    = 1'b0;
      case (work_ff.kind)
         KIND_CONST_WR: step = 9'sd0;
         KIND_REG_OP: begin
            wr = 1'b1;
            case (work_ff.opcode)
               OP_LOADCONST: val = cval_ff;
               OP_ADD:       val = opb_ff + opc_ff;
               OP_SUB:       val = opb_ff - opc_ff;
               OP_LOADIMM:   val = VW'(work_ff.field_b);
               default:      val = opb_ff;
            endcase
         end
         KIND_MUL: wr = 1'b1;
         KIND_DIV: begin
            wr = 1'b1;
            dz = 1'b1;
         end
         KIND_CMP: begin
            case (work_ff.opcode)
               OP_EQ:   cmp = (opb_ff == opc_ff);
               OP_LT:   cmp = ($signed(opb_ff) <  $signed(opc_ff));
               OP_LE:   cmp = ($signed(opb_ff) <= $signed(opc_ff));
               OP_GT:   cmp = ($signed(opb_ff) >  $signed(opc_ff));
               default: cmp = ($signed(opb_ff) >= $signed(opc_ff));
            endcase
            if (rval0 == VW'(cmp)) begin
               step = 9'sd2;
            end
         end
         KIND_JMP:  step = 9'(work_ff.jump_offset) + 9'sd1;
         KIND_HALT: halted = 1'b1;
         default: ;
      endcase
      if (state_ff == BS_FIN) begin
         val = fin_val_ff;
         dz  = 1'b0;
      end
   end

   assign wr_en = fire & wr & reg_ok(work_ff.field_a);

   always_comb begin
      rsp_in.pc_step       = step;
      rsp_in.halted        = halted;
      rsp_in.reg_written   = wr_en;
      rsp_in.written_value = wr_en ? 32'(val) : 32'sd0;
      rsp_in.div_zero      = dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGISTERS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            vld_ff[RW'(work_ff.field_a)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         work_ff <= in_entry;
         cval_ff <= in_value;
      end
      if (state_ff == BS_LOAD) begin
         opb_ff <= rval0;
         opc_ff <= rval1;
      end
      if (iter_done) begin
         fin_val_ff <= iter_result;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
      if (rd_en) begin
         rok0_ff <= reg_ok(addr0) && vld_ff[RW'(addr0)];
         rok1_ff <= reg_ok(addr1) && vld_ff[RW'(addr1)];
      end
   end

   // register file, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rmem[RW'(work_ff.field_a)] <= val;
      end
      if (rd_en) begin
         rdata0_ff <= rmem[RW'(addr0)];
         rdata1_ff <= rmem[RW'(addr1)];
      end
   end

   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_iter_kind : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_ITER) |-> (work_ff.kind == KIND_MUL || work_ff.kind == KIND_DIV))
      else $error("iterating on a non multiply/divide instruction");

   a_done_in_iter : assert property (@(posedge clock) disable iff (reset)
      iter_done |-> (state_ff == BS_ITER))
      else $error("iterative unit finished outside the wait state");

   a_fin_after_iter : assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_FIN) |-> ($past(state_ff) == BS_ITER || $past(state_ff) == BS_FIN))
      else $error("finish state entered without iteration");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      fire |-> (!rsp_valid_ff || rsp_pop))
      else $error("result overwritten before it was taken");

endmodule

>>> src/register_vm_instruction_executor.sv
// channel   direction  handshake          payload
// req       in         push / full        rvie_pkg::req_type
// rsp       out        pop / empty        rvie_pkg::rsp_type
//
// simple instructions and constant writes go through back end states idle, load, exec
// multiply and divide by a non-zero divisor also pass iter and fin, one bit a cycle
// in the shared iterative unit; a zero divisor takes the simple path
// front stage reads the constant store and classifies, a two-deep queue decouples it
// reset is synchronous and clears control state and the register file valid bits
// a result held on rsp stalls the back end only when the next one is ready
module register_vm_instruction_executor #(
   parameter int NUM_REGISTERS = 256,
   parameter int NUM_CONSTANTS = 1024,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  rvie_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output rvie_pkg::rsp_type rsp_data
);
   import rvie_pkg::*;

   localparam int QW = $bits(entry_type) + VALUE_WIDTH;

   // front to queue
   logic                   f_valid;
   entry_type              f_entry;
   logic [VALUE_WIDTH-1:0] f_value;
   logic                   q_full;

   // queue to back
   logic                   q_empty;
   logic                   q_pop;
   logic [QW-1:0]          q_dout;
   entry_type              b_entry;
   logic [VALUE_WIDTH-1:0] b_value;

   rvie_front #(
      .NUM_CONSTANTS (NUM_CONSTANTS),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req       (req_data),
      .out_valid (f_valid),
      .out_entry (f_entry),
      .out_value (f_value),
      .out_full  (q_full)
   );

   // decoupling queue, value beside the decoded entry
   rvie_fifo #(.WIDTH(QW)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (f_valid),
      .full  (q_full),
      .din   ({f_value, f_entry}),
      .pop   (q_pop),
      .empty (q_empty),
      .dout  (q_dout)
   );

   assign {b_value, b_entry} = q_dout;

   rvie_back #(
      .NUM_REGISTERS (NUM_REGISTERS),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (~q_empty),
      .in_pop    (q_pop),
      .in_entry  (b_entry),
      .in_value  (b_value),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule
